// ===== src/fdt_pkg.sv =====
package fdt_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TRIAL_GO,
        S_TRIAL_WAIT,
        S_LEG_GO,
        S_LEG_WAIT,
        S_OUT
    } fdt_state_t;

endpackage

// ===== src/fdt_req_if.sv =====
interface fdt_req_if #(
    parameter int unsigned VALUE_WIDTH = fdt_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] factorial_base;
    logic [VALUE_WIDTH-1:0] divisor_value;

    modport source (output valid, output factorial_base, output divisor_value, input ready);
    modport sink   (input valid, input factorial_base, input divisor_value, output ready);
endinterface

// ===== src/fdt_rsp_if.sv =====
interface fdt_rsp_if;
    logic valid;
    logic ready;
    logic divides;

    modport source (output valid, output divides, input ready);
    modport sink   (input valid, input divides, output ready);
endinterface

// ===== src/fdt_div.sv =====
module fdt_div #(
    parameter int unsigned VALUE_WIDTH = fdt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);
    localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvsr_reg, dvsr_next;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   diff;

    assign rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH);
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            if (diff[VALUE_WIDTH])
            begin
                rem_next = rem_shift[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ===== src/factorial_divisibility_test.sv =====
// factorial divisibility test: answers whether m divides n factorial
// request channel (req): factorial_base = n, divisor_value = m, taken on valid && ready
// response channel (rsp): divides = 1 when m divides n!, one response per request
// m is factored by trial division (2, then odd divisors while d*d <= what is left of m)
// each prime power is checked by legendre's sum with early exit
// every trial or legendre step uses one shared restoring divider; m = 0 is answered
// without any division, and the worst case (m a large prime) needs about 23000
// divisions at the default width
// the block takes one request at a time: req.ready is high only when it is idle
// the answer is held on rsp until taken; a stalled receiver keeps the block waiting
// reset clears the sequencer and divider control; no clearing pass is needed
module factorial_divisibility_test #(
    parameter int unsigned VALUE_WIDTH = fdt_pkg::VALUE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fdt_req_if.sink   req,
    fdt_rsp_if.source rsp
);
    localparam int unsigned EW = $clog2(VALUE_WIDTH + 1);

    fdt_pkg::fdt_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] rest_reg, rest_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH+1:0] d_sq_reg, d_sq_next;
    logic [VALUE_WIDTH-1:0] p_reg, p_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [VALUE_WIDTH:0]   total_reg, total_next;
    logic [EW-1:0]          e_reg, e_next;
    logic                   result_reg, result_next;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_divisor;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    logic                   in_fire;
    logic                   sq_fits;
    logic [VALUE_WIDTH:0]   sum;
    logic                   enough;
    logic [VALUE_WIDTH-1:0] d_adv;
    logic [VALUE_WIDTH+1:0] d_sq_adv;

    fdt_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_fire  = req.valid && req.ready;
    assign sq_fits  = d_sq_reg <= {2'b00, rest_reg};
    assign sum      = total_reg + {1'b0, div_quo};
    assign enough   = sum >= (VALUE_WIDTH + 1)'(e_reg);
    assign d_adv    = (d_reg == VALUE_WIDTH'(2)) ? VALUE_WIDTH'(3) : d_reg + VALUE_WIDTH'(2);
    assign d_sq_adv = (d_reg == VALUE_WIDTH'(2)) ? (VALUE_WIDTH + 2)'(9)
                    : d_sq_reg + {d_reg, 2'b00} + (VALUE_WIDTH + 2)'(4);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (req.divisor_value == '0)
                        state_next = fdt_pkg::S_OUT;
                    else
                        state_next = fdt_pkg::S_CHECK;
                end
            end
            fdt_pkg::S_CHECK:
            begin
                if (sq_fits)
                    state_next = fdt_pkg::S_TRIAL_GO;
                else if (rest_reg > VALUE_WIDTH'(1))
                    state_next = fdt_pkg::S_LEG_GO;
                else
                    state_next = fdt_pkg::S_OUT;
            end
            fdt_pkg::S_TRIAL_GO:
                state_next = fdt_pkg::S_TRIAL_WAIT;
            fdt_pkg::S_TRIAL_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                        state_next = fdt_pkg::S_TRIAL_GO;
                    else if (e_reg != '0)
                        state_next = fdt_pkg::S_LEG_GO;
                    else
                        state_next = fdt_pkg::S_CHECK;
                end
            end
            fdt_pkg::S_LEG_GO:
            begin
                if (q_reg == '0)
                    state_next = fdt_pkg::S_OUT;
                else
                    state_next = fdt_pkg::S_LEG_WAIT;
            end
            fdt_pkg::S_LEG_WAIT:
            begin
                if (div_done)
                begin
                    if (enough)
                        state_next = fdt_pkg::S_CHECK;
                    else
                        state_next = fdt_pkg::S_LEG_GO;
                end
            end
            fdt_pkg::S_OUT:
            begin
                if (rsp.ready)
                    state_next = fdt_pkg::S_IDLE;
            end
            default:
                state_next = fdt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready    = 1'b0;
        rsp.valid    = 1'b0;
        div_start    = 1'b0;
        div_dividend = rest_reg;
        div_divisor  = d_reg;
        case (state_reg)
            fdt_pkg::S_IDLE:
                req.ready = 1'b1;
            fdt_pkg::S_TRIAL_GO:
                div_start = 1'b1;
            fdt_pkg::S_LEG_GO:
            begin
                div_start    = q_reg != '0;
                div_dividend = q_reg;
                div_divisor  = p_reg;
            end
            fdt_pkg::S_OUT:
                rsp.valid = 1'b1;
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign rsp.divides = result_reg;

    // datapath
    always_comb
    begin
        n_next      = n_reg;
        rest_next   = rest_reg;
        d_next      = d_reg;
        d_sq_next   = d_sq_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        total_next  = total_reg;
        e_next      = e_reg;
        result_next = result_reg;
        case (state_reg)
            fdt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    n_next      = req.factorial_base;
                    rest_next   = req.divisor_value;
                    d_next      = VALUE_WIDTH'(2);
                    d_sq_next   = (VALUE_WIDTH + 2)'(4);
                    e_next      = '0;
                    result_next = 1'b0;
                end
            end
            fdt_pkg::S_CHECK:
            begin
                if (!sq_fits)
                begin
                    if (rest_reg > VALUE_WIDTH'(1))
                    begin
                        // last prime left over
                        p_next     = rest_reg;
                        rest_next  = VALUE_WIDTH'(1);
                        e_next     = EW'(1);
                        q_next     = n_reg;
                        total_next = '0;
                    end
                    else
                        result_next = 1'b1;
                end
            end
            fdt_pkg::S_TRIAL_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        rest_next = div_quo;
                        e_next    = e_reg + EW'(1);
                    end
                    else if (e_reg != '0)
                    begin
                        p_next     = d_reg;
                        q_next     = n_reg;
                        total_next = '0;
                    end
                    else
                    begin
                        d_next    = d_adv;
                        d_sq_next = d_sq_adv;
                    end
                end
            end
            fdt_pkg::S_LEG_GO:
            begin
                if (q_reg == '0)
                    result_next = 1'b0;
            end
            fdt_pkg::S_LEG_WAIT:
            begin
                if (div_done)
                begin
                    q_next     = div_quo;
                    total_next = sum;
                    if (enough)
                    begin
                        e_next    = '0;
                        d_next    = d_adv;
                        d_sq_next = d_sq_adv;
                    end
                end
            end
            default:
            begin
                result_next = result_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fdt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        rest_reg   <= rest_next;
        d_reg      <= d_next;
        d_sq_reg   <= d_sq_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        total_reg  <= total_next;
        e_reg      <= e_next;
        result_reg <= result_next;
    end

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == fdt_pkg::S_TRIAL_WAIT || state_reg == fdt_pkg::S_LEG_WAIT))
        else $error("divider finished outside a wait state");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != fdt_pkg::S_IDLE)
        else $error("request taken but sequencer stayed idle");

    a_rest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fdt_pkg::S_CHECK |-> rest_reg != '0)
        else $error("remaining divisor reached zero");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> div_divisor > VALUE_WIDTH'(1))
        else $error("divider started with a divisor below two");
endmodule

// ===== sim/factorial_divisibility_test_test.sv =====
`timescale 1ns / 100ps

module factorial_divisibility_test_test;

    localparam int unsigned VW = fdt_pkg::VALUE_WIDTH_DEF;
    localparam int unsigned N_RANDOM = 80;
    localparam int unsigned DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [VW-1:0] base;
        logic [VW-1:0] divisor;
    } fdt_request_t;

    logic clk;
    logic rst_n;

    fdt_req_if #(.VALUE_WIDTH(VW)) req_ch ();
    fdt_rsp_if rsp_ch ();

    factorial_divisibility_test #(.VALUE_WIDTH(VW)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fdt_request_t pending_requests[$];
    logic         expected_divides[$];
    int unsigned  n_total;
    int unsigned  n_accepted;
    int unsigned  n_answered;
    int unsigned  n_divides;
    int unsigned  n_errors;
    int unsigned  sender_idle;
    int unsigned  receiver_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // legendre check for one prime power: exponent of p in n! at least e
    function automatic bit prime_power_in_factorial(longint unsigned n, longint unsigned p,
                                                    longint unsigned e);
        longint unsigned power;
        longint unsigned total;
        power = 1;
        total = 0;
        while (power < n)
        begin
            power = power * p;
            total = total + n / power;
            if (total >= e)
                return 1'b1;
        end
        return total >= e;
    endfunction

    function automatic logic divides_factorial(logic [VW-1:0] n_in, logic [VW-1:0] m_in);
        longint unsigned n;
        longint unsigned rest;
        longint unsigned d;
        longint unsigned e;
        n = n_in;
        rest = m_in;
        d = 2;
        if (rest == 0)
            return 1'b0;
        while (d * d <= rest)
        begin
            if (rest % d == 0)
            begin
                e = 0;
                while (rest % d == 0)
                begin
                    rest = rest / d;
                    e++;
                end
                if (!prime_power_in_factorial(n, d, e))
                    return 1'b0;
            end
            d = (d == 2) ? 3 : d + 2;
        end
        if (rest > 1 && !prime_power_in_factorial(n, rest, 1))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [VW-1:0] random_smooth_divisor();
        int unsigned     primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
        longint unsigned product;
        longint unsigned p;
        int unsigned     count;
        product = 1;
        count = $urandom_range(1, 10);
        for (int i = 0; i < count; i++)
        begin
            p = primes[$urandom_range(0, 14)];
            if (product * p < (64'd1 << VW))
                product = product * p;
        end
        return product[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] random_base();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return VW'($urandom_range(0, 60));
        else if (pick < 80)
            return VW'($urandom_range(0, 5000));
        else
            return VW'($urandom);
    endfunction

    function automatic logic [VW-1:0] random_divisor();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return random_smooth_divisor();
        else if (pick < 75)
            return VW'($urandom_range(0, 4096));
        else if (pick < 92)
            return VW'($urandom_range(0, 65535));
        else
            return VW'($urandom_range(0, 1 << 20));
    endfunction

    // idle split changes with progress through the requests
    always_comb
    begin
        if (n_accepted < n_total / 3)
        begin
            sender_idle = 17;
            receiver_idle = 68;
        end
        else if (n_accepted < 2 * n_total / 3)
        begin
            sender_idle = 68;
            receiver_idle = 17;
        end
        else
        begin
            sender_idle = 0;
            receiver_idle = 0;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.factorial_base <= '0;
            req_ch.divisor_value <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle)
            begin
                req_ch.valid <= 1'b1;
                req_ch.factorial_base <= pending_requests[0].base;
                req_ch.divisor_value <= pending_requests[0].divisor;
                void'(pending_requests.pop_front());
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    // monitor: predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_divides = {expected_divides,
                    divides_factorial(req_ch.factorial_base, req_ch.divisor_value)};
                n_accepted <= n_accepted + 1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_answered <= n_answered + 1;
                if (rsp_ch.divides)
                    n_divides <= n_divides + 1;
                if (expected_divides.size() == 0)
                begin
                    $error("unexpected response: divides=%0b", rsp_ch.divides);
                    n_errors <= n_errors + 1;
                end
                else
                begin
                    if (rsp_ch.divides !== expected_divides[0])
                    begin
                        $error("divides mismatch: expected %0b, actual %0b",
                               expected_divides[0], rsp_ch.divides);
                        n_errors <= n_errors + 1;
                    end
                    void'(expected_divides.pop_front());
                end
            end
        end
    end

    task automatic add_request(logic [VW-1:0] base, logic [VW-1:0] divisor);
        fdt_request_t r;
        r.base = base;
        r.divisor = divisor;
        pending_requests = {pending_requests, r};
    endtask

    initial
    begin
        logic [VW-1:0] all_ones;
        all_ones = '1;
        n_accepted = 0;
        n_answered = 0;
        n_divides = 0;
        n_errors = 0;
        rst_n = 1'b0;

        // directed: zero and unit cases, extremes, prime powers at the edge
        add_request(VW'(0), VW'(0));
        add_request(VW'(0), VW'(1));
        add_request(VW'(1), VW'(1));
        add_request(VW'(0), VW'(2));
        add_request(VW'(1), VW'(2));
        add_request(all_ones, VW'(0));
        add_request(all_ones, VW'(1));
        add_request(VW'(5), VW'(120));
        add_request(VW'(5), VW'(121));
        add_request(VW'(5), VW'(240));
        add_request(VW'(3), VW'(4));
        add_request(VW'(10), VW'(256));
        add_request(VW'(10), VW'(512));
        add_request(VW'(32), VW'(1 << 30));
        add_request(VW'(31), VW'(1 << 30));
        add_request(all_ones, VW'(32'h7FFF_FFFE));
        add_request(VW'(32'h5555_5555), VW'(32'h2AAA_AAAA));
        add_request(VW'(32'h2AAA_AAAA), VW'(32'h5555_5555));
        add_request(VW'(100), VW'(9973));
        add_request(VW'(9973), VW'(9973));
        add_request(VW'(131074), VW'(131074));
        add_request(VW'(2), VW'(65537 * 3));
        for (int i = 0; i < N_RANDOM; i++)
            add_request(random_base(), random_divisor());
        n_total = pending_requests.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_accepted == n_total && expected_divides.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests checked, %0d answered 'divides'", n_answered, n_divides);
        $display("zero, unit and extreme operands under all three idle mixes");
        if (n_errors == 0 && expected_divides.size() == 0)
            $display("factorial_divisibility_test regression: pass");
        else
            $display("factorial_divisibility_test regression: fail");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("factorial_divisibility_test regression: fail");
        $finish;
    end

endmodule
